// ----- rtl/bpig_pkg.sv -----
// ============================================================================
// bpig_pkg
// Shared constants for the inverted-gray bitmap pixel converter.
// ============================================================================
package bpig_pkg;

  // Default sizing of the core.
  localparam int MAX_WIDTH_DEFAULT     = 4096;
  localparam int PALETTE_DEPTH_DEFAULT = 256;

  // Field and register widths.
  localparam int BYTE_W   = 8;
  localparam int COLOR_W  = 3 * BYTE_W;
  localparam int CFG_W    = 13;
  localparam int ROW_W    = 12;
  localparam int HEIGHT_LIMIT = 4096;

  // Configuration register indexes.
  localparam logic [1:0] REG_PIXEL_BYTES  = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  // Input beat kinds.
  localparam logic MODE_PIXEL   = 1'b0;
  localparam logic MODE_PALETTE = 1'b1;

  // Bytes per pixel in BGR mode.
  localparam logic [1:0] BPP_BGR24 = 2'd3;

  // Division by three: (x * 683) >> 11 is exact for x below 2045.
  localparam int SUM_W      = 10;
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;
  localparam int PROD_W     = 2 * SUM_W;
  localparam logic [BYTE_W-1:0] GRAY_MAX = 8'd255;

endpackage

// ----- rtl/bmp_pixel_to_inverted_gray_core.sv -----
// ============================================================================
// bmp_pixel_to_inverted_gray_core
// Turns bitmap pixel-data bytes into inverted gray levels, one byte a beat.
// ============================================================================
// A result passes through stage 1, where the palette is read, and the output
// register, which takes the gray arithmetic, before it shows on out_valid.
// Input is taken at one beat per cycle while the output does not stall; the
// single palette read port sets the pipeline depth, not the rate.
// Reset clears the counters, the byte phase and the pipeline valids; the
// palette is undefined until written and needs no clearing pass.
module bmp_pixel_to_inverted_gray_core #(
  parameter int MAX_WIDTH     = bpig_pkg::MAX_WIDTH_DEFAULT,
  parameter int PALETTE_DEPTH = bpig_pkg::PALETTE_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  // Configuration
  input  logic                        cfg_write,
  input  logic [1:0]                  cfg_index,
  input  logic [bpig_pkg::CFG_W-1:0]  cfg_data,
  // Input channel
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        mode,
  input  logic [bpig_pkg::BYTE_W-1:0] pixel_byte,
  input  logic [bpig_pkg::BYTE_W-1:0] palette_index,
  input  logic [bpig_pkg::BYTE_W-1:0] palette_red,
  input  logic [bpig_pkg::BYTE_W-1:0] palette_green,
  input  logic [bpig_pkg::BYTE_W-1:0] palette_blue,
  // Output channel
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bpig_pkg::BYTE_W-1:0] gray_level,
  output logic                        row_end,
  output logic                        image_end
);
  import bpig_pkg::*;

  localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;

  // Configuration registers.
  logic [1:0]       pixel_bytes;
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_bytes  <= BPP_BGR24;
      image_width  <= CFG_W'(1);
      image_height <= CFG_W'(1);
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_PIXEL_BYTES:  pixel_bytes  <= cfg_data[1:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stream state.
  logic [1:0]        byte_phase;
  logic [BYTE_W-1:0] held_blue;
  logic [BYTE_W-1:0] held_green;
  logic [CW-1:0]     column_count;
  logic [ROW_W-1:0]  row_count;
  logic [1:0]        pad_remaining;

  // Pipeline registers.
  logic              s1_valid;
  logic              s1_use_palette;
  logic              s1_oob;
  logic [BYTE_W-1:0] s1_red;
  logic [BYTE_W-1:0] s1_green;
  logic [BYTE_W-1:0] s1_blue;
  logic              s1_row_end;
  logic              s1_image_end;
  logic [COLOR_W-1:0] palette_rd_data;

  logic accept, pixel_beat, palette_beat, bgr_mode, makes_pixel, out_load;
  logic pal_write_en, pal_read_en, index_oob;
  logic last_col, last_row;
  logic [WW-1:0]    width_ext, width_eff;
  logic [CFG_W-1:0] height_eff;
  logic [1:0]       pad_next;

  assign out_load = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || out_load;
  assign accept   = in_valid && in_ready;

  assign palette_beat = accept && (mode == MODE_PALETTE);
  assign pixel_beat   = accept && (mode == MODE_PIXEL) && (pad_remaining == 2'd0);
  assign bgr_mode     = (pixel_bytes == BPP_BGR24);
  assign makes_pixel  = pixel_beat && (!bgr_mode || (byte_phase == 2'd2));

  assign pal_write_en = palette_beat &&
                        ({1'b0, palette_index} < (BYTE_W + 1)'(PALETTE_DEPTH));
  assign index_oob    = !({1'b0, pixel_byte} < (BYTE_W + 1)'(PALETTE_DEPTH));
  assign pal_read_en  = makes_pixel && !bgr_mode && !index_oob;

  // Effective geometry: zero counts as one, large values saturate.
  assign width_ext = WW'(image_width);
  always_comb begin
    if (width_ext == '0) begin
      width_eff = WW'(1);
    end else if (width_ext > WW'(MAX_WIDTH)) begin
      width_eff = WW'(MAX_WIDTH);
    end else begin
      width_eff = width_ext;
    end
    if (image_height == '0) begin
      height_eff = CFG_W'(1);
    end else if (image_height > CFG_W'(HEIGHT_LIMIT)) begin
      height_eff = CFG_W'(HEIGHT_LIMIT);
    end else begin
      height_eff = image_height;
    end
  end

  assign last_col = (WW'(column_count) + WW'(1)) >= width_eff;
  assign last_row = (CFG_W'(row_count) + CFG_W'(1)) >= height_eff;
  // Row bytes of width*3 need width mod 4 pad bytes; width*1 needs -width mod 4.
  assign pad_next = bgr_mode ? width_eff[1:0] : (2'd0 - width_eff[1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase    <= 2'd0;
      column_count  <= '0;
      row_count     <= '0;
      pad_remaining <= 2'd0;
    end else if (accept && (mode == MODE_PIXEL)) begin
      if (pad_remaining != 2'd0) begin
        pad_remaining <= pad_remaining - 2'd1;
      end else begin
        if (bgr_mode && (byte_phase != 2'd2)) begin
          byte_phase <= byte_phase + 2'd1;
        end else begin
          byte_phase <= 2'd0;
        end
        if (makes_pixel) begin
          if (last_col) begin
            column_count  <= '0;
            pad_remaining <= pad_next;
            row_count     <= last_row ? '0 : row_count + ROW_W'(1);
          end else begin
            column_count  <= column_count + CW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_beat && bgr_mode && (byte_phase == 2'd0)) begin
      held_blue <= pixel_byte;
    end
    if (pixel_beat && bgr_mode && (byte_phase == 2'd1)) begin
      held_green <= pixel_byte;
    end
  end

  // Palette memory. A write and a read never fall in the same cycle, and a
  // read in the cycle after a write sees the new entry.
  logic [COLOR_W-1:0] palette_mem [PALETTE_DEPTH];

  always_ff @(posedge clk) begin
    if (pal_write_en) begin
      palette_mem[palette_index[AW-1:0]] <= {palette_red, palette_green, palette_blue};
    end
    if (pal_read_en) begin
      palette_rd_data <= palette_mem[pixel_byte[AW-1:0]];
    end
  end

  // Stage 1: pixel colour and position flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (makes_pixel) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (makes_pixel) begin
      s1_use_palette <= !bgr_mode;
      s1_oob         <= !bgr_mode && index_oob;
      s1_red         <= pixel_byte;
      s1_green       <= held_green;
      s1_blue        <= held_blue;
      s1_row_end     <= last_col;
      s1_image_end   <= last_col && last_row;
    end
  end

  logic [BYTE_W-1:0] red, green, blue;
  logic [SUM_W-1:0]  sum;
  logic [PROD_W-1:0] prod;

  always_comb begin
    if (s1_oob) begin
      red   = '0;
      green = '0;
      blue  = '0;
    end else if (s1_use_palette) begin
      red   = palette_rd_data[COLOR_W-1 -: BYTE_W];
      green = palette_rd_data[BYTE_W +: BYTE_W];
      blue  = palette_rd_data[BYTE_W-1:0];
    end else begin
      red   = s1_red;
      green = s1_green;
      blue  = s1_blue;
    end
  end

  assign sum  = SUM_W'(2) + SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);
  assign prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      gray_level <= GRAY_MAX - prod[DIV3_SHIFT +: BYTE_W];
      row_end    <= s1_row_end;
      image_end  <= s1_image_end;
    end
  end

  // The last pixel of an image is always the last pixel of its row.
  a_image_end_on_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!image_end || row_end))
    else $error("image_end without row_end");

  // The byte phase only counts through blue, green, red.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    byte_phase != 2'd3)
    else $error("byte_phase out of range");

  // Padding is only skipped between whole pixels.
  a_pad_between_pixels: assert property (@(posedge clk) disable iff (rst)
    (pad_remaining != 2'd0) |-> (byte_phase == 2'd0))
    else $error("padding inside a pixel");

  // A held stage 1 result blocks new input.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while stage 1 is stalled");

endmodule

// ----- test/bmp_pixel_to_inverted_gray_core_tb.sv -----
// ============================================================================
// bmp_pixel_to_inverted_gray_core_tb
// Drives bitmap pixel-data bytes and palette writes into the converter under
// several register settings, predicts each inverted gray level together with
// its row and image end flags, and compares every result beat in order.
// ============================================================================
`timescale 1ns / 1ps

module bmp_pixel_to_inverted_gray_core_tb;
  import bpig_pkg::*;

  localparam int RESET_CYCLES  = 7;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 120;
  localparam int CYCLE_LIMIT   = 300000;

  localparam logic [1:0] BPP_PALETTE8 = 2'd1;

  typedef enum logic [1:0] {PHASE_BLUE, PHASE_GREEN, PHASE_RED} byte_phase_t;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] data;
    logic [BYTE_W-1:0] index;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } pixel_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] gray;
    logic              row_end;
    logic              image_end;
  } gray_result_t;

  typedef struct packed {
    logic [1:0]       bpp;
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    int               beats;
    bit               calm_phase;
  } phase_plan_t;

  // Small sizes carry most of the traffic; the saturating widths and heights
  // get only a short stretch, and the counters carry over into the next plan.
  localparam phase_plan_t PLANS [11] = '{
    '{2'd3, 13'd5,    13'd3,    260, 1'b0},
    '{2'd1, 13'd7,    13'd2,    220, 1'b0},
    '{2'd0, 13'd3,    13'd4,    180, 1'b1},
    '{2'd2, 13'd4,    13'd1,    180, 1'b0},
    '{2'd3, 13'd0,    13'd0,    160, 1'b0},
    '{2'd1, 13'd1,    13'd4096, 120, 1'b0},
    '{2'd3, 13'd8191, 13'd8191, 60,  1'b0},
    '{2'd3, 13'd4096, 13'd5,    60,  1'b0},
    '{2'd1, 13'd2,    13'd3,    160, 1'b0},
    '{2'd3, 13'd6,    13'd2,    200, 1'b0},
    '{2'd3, 13'd1,    13'd1,    200, 1'b1}
  };

  class gray_level_checker;
    logic [1:0]         pixel_bytes;
    logic [CFG_W-1:0]   image_width;
    logic [CFG_W-1:0]   image_height;
    logic [COLOR_W-1:0] color_table [PALETTE_DEPTH_DEFAULT];
    bit                 color_written [PALETTE_DEPTH_DEFAULT];
    byte_phase_t        byte_phase;
    logic [BYTE_W-1:0]  held_blue;
    logic [BYTE_W-1:0]  held_green;
    logic [ROW_W-1:0]   column_count;
    logic [ROW_W-1:0]   row_count;
    logic [1:0]         pad_left;
    gray_result_t       pending_grays [$];
    int                 mismatches;
    int                 beat_count;
    int                 gray_count;
    int                 row_end_count;
    int                 image_end_count;

    function new();
      pixel_bytes     = BPP_BGR24;
      image_width     = 1;
      image_height    = 1;
      byte_phase      = PHASE_BLUE;
      held_blue       = '0;
      held_green      = '0;
      column_count    = '0;
      row_count       = '0;
      pad_left        = '0;
      mismatches      = 0;
      beat_count      = 0;
      gray_count      = 0;
      row_end_count   = 0;
      image_end_count = 0;
      foreach (color_written[i]) color_written[i] = 1'b0;
    endfunction

    function void set_register(logic [1:0] idx, logic [CFG_W-1:0] value);
      case (idx)
        REG_PIXEL_BYTES:  pixel_bytes  = value[1:0];
        REG_IMAGE_WIDTH:  image_width  = value;
        REG_IMAGE_HEIGHT: image_height = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return pending_grays.size();
    endfunction

    function void note_input(pixel_beat_t beat);
      logic [BYTE_W-1:0] red, green, blue;
      int                width, height, sum;
      bit                bgr, last_col, last_row;
      gray_result_t      res;
      beat_count++;
      if (beat.kind == MODE_PALETTE) begin
        color_table[beat.index]   = {beat.red, beat.green, beat.blue};
        color_written[beat.index] = 1'b1;
        return;
      end
      if (pad_left != 0) begin
        pad_left--;
        return;
      end
      bgr = (pixel_bytes == BPP_BGR24);
      if (bgr) begin
        if (byte_phase == PHASE_BLUE) begin
          held_blue  = beat.data;
          byte_phase = PHASE_GREEN;
          return;
        end
        if (byte_phase == PHASE_GREEN) begin
          held_green = beat.data;
          byte_phase = PHASE_RED;
          return;
        end
        byte_phase = PHASE_BLUE;
        red   = beat.data;
        green = held_green;
        blue  = held_blue;
      end else begin
        byte_phase = PHASE_BLUE;
        {red, green, blue} = color_table[beat.data];
      end
      sum      = 2 + red + green + blue;
      res.gray = 8'(int'(GRAY_MAX) - sum / 3);

      width = (image_width == 0) ? 1 : int'(image_width);
      if (width > MAX_WIDTH_DEFAULT) width = MAX_WIDTH_DEFAULT;
      height = (image_height == 0) ? 1 : int'(image_height);
      if (height > HEIGHT_LIMIT) height = HEIGHT_LIMIT;

      last_col = (column_count + 1 >= width);
      last_row = 1'b0;
      if (last_col) begin
        column_count = '0;
        // Rows are padded to a multiple of four bytes.
        pad_left  = 2'((4 - ((width * (bgr ? 3 : 1)) % 4)) % 4);
        last_row  = (row_count + 1 >= height);
        row_count = last_row ? '0 : row_count + 1'b1;
      end else begin
        column_count++;
      end
      res.row_end   = last_col;
      res.image_end = last_row;
      pending_grays.push_back(res);
    endfunction

    function void check_result(logic [BYTE_W-1:0] gray, logic row_end, logic image_end);
      gray_result_t want;
      if (pending_grays.size() == 0) begin
        $error("Unexpected result beat: gray_level %0d row_end %0b image_end %0b",
               gray, row_end, image_end);
        mismatches++;
        return;
      end
      want = pending_grays.pop_front();
      gray_count++;
      if (row_end === 1'b1) row_end_count++;
      if (image_end === 1'b1) image_end_count++;
      if (gray !== want.gray) begin
        $error("gray_level: expected %0d, got %0d", want.gray, gray);
        mismatches++;
      end
      if (row_end !== want.row_end) begin
        $error("row_end: expected %0b, got %0b", want.row_end, row_end);
        mismatches++;
      end
      if (image_end !== want.image_end) begin
        $error("image_end: expected %0b, got %0b", want.image_end, image_end);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk           = 1'b0;
  logic              rst           = 1'b1;
  logic              cfg_write     = 1'b0;
  logic [1:0]        cfg_index     = REG_PIXEL_BYTES;
  logic [CFG_W-1:0]  cfg_data      = '0;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  logic              mode          = MODE_PIXEL;
  logic [BYTE_W-1:0] pixel_byte    = '0;
  logic [BYTE_W-1:0] palette_index = '0;
  logic [BYTE_W-1:0] palette_red   = '0;
  logic [BYTE_W-1:0] palette_green = '0;
  logic [BYTE_W-1:0] palette_blue  = '0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic [BYTE_W-1:0] gray_level;
  logic              row_end;
  logic              image_end;

  bit                calm         = 1'b0;
  bit                hold_request = 1'b0;
  int                cycle_count  = 0;
  gray_level_checker sb = new();

  bmp_pixel_to_inverted_gray_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .mode          (mode),
    .pixel_byte    (pixel_byte),
    .palette_index (palette_index),
    .palette_red   (palette_red),
    .palette_green (palette_green),
    .palette_blue  (palette_blue),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .gray_level    (gray_level),
    .row_end       (row_end),
    .image_end     (image_end)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(gray_level, row_end, image_end);
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  function automatic logic [BYTE_W-1:0] rand8();
    return 8'($urandom_range(0, 255));
  endfunction

  // Pixel bytes lean toward the extremes now and then to reach gray 0 and 255.
  function automatic logic [BYTE_W-1:0] pixel_value();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return rand8();
    endcase
  endfunction

  task automatic send_beat(input logic kind, input logic [BYTE_W-1:0] value,
                           input logic [BYTE_W-1:0] index, input logic [BYTE_W-1:0] red,
                           input logic [BYTE_W-1:0] green, input logic [BYTE_W-1:0] blue);
    pixel_beat_t beat;
    beat = '{kind: kind, data: value, index: index, red: red, green: green, blue: blue};
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    mode          <= kind;
    pixel_byte    <= value;
    palette_index <= index;
    palette_red   <= red;
    palette_green <= green;
    palette_blue  <= blue;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(beat);
  endtask

  task automatic send_palette(input logic [BYTE_W-1:0] index, input logic [BYTE_W-1:0] red,
                              input logic [BYTE_W-1:0] green, input logic [BYTE_W-1:0] blue);
    send_beat(MODE_PALETTE, rand8(), index, red, green, blue);
  endtask

  // In palette mode an entry is always loaded before any byte can look it up.
  task automatic send_pixel(input logic [BYTE_W-1:0] value);
    if (sb.pixel_bytes != BPP_BGR24 && !sb.color_written[value])
      send_palette(value, rand8(), rand8(), rand8());
    send_beat(MODE_PIXEL, value, rand8(), rand8(), rand8(), rand8());
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [1:0] bpp, input logic [CFG_W-1:0] width,
                               input logic [CFG_W-1:0] height);
    logic [1:0]       regs [3];
    logic [CFG_W-1:0] vals [3];
    regs = '{REG_PIXEL_BYTES, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT};
    vals = '{CFG_W'(bpp), width, height};
    cfg_write <= 1'b1;
    for (int i = 0; i < 3; i++) begin
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
      sb.set_register(regs[i], vals[i]);
    end
    cfg_write <= 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Reset setting: BGR, one pixel per row and per image, one pad byte.
    repeat (4) send_pixel(8'h00);
    repeat (4) send_pixel(8'hFF);
    // A palette write between the blue and green bytes must not disturb the pixel.
    send_pixel(8'h01);
    send_palette(8'h80, 8'hFF, 8'h00, 8'hFF);
    repeat (3) send_pixel(8'h00);
    wait_for_results();

    // Palette mode, 2x2 image, two pad bytes per row.
    apply_setting(BPP_PALETTE8, 13'd2, 13'd2);
    send_palette(8'h00, 8'hFF, 8'hFF, 8'hFF);
    send_palette(8'hFF, 8'h00, 8'h00, 8'h00);
    repeat (2) begin
      send_pixel(8'h00);
      send_pixel(8'hFF);
      repeat (2) send_pixel(8'h00);
    end

    for (int p = 0; p < $size(PLANS); p++) begin
      wait_for_results();
      calm = PLANS[p].calm_phase;
      apply_setting(PLANS[p].bpp, PLANS[p].width, PLANS[p].height);
      for (int i = 0; i < PLANS[p].beats; i++) begin
        // Starve the result side for a while so the block backs up.
        if (p == 0 && i == 40) hold_request = 1'b1;
        if (p == 3 && i == PLANS[p].beats / 2) wait_for_results();
        if ($urandom_range(0, 9) == 0) send_palette(rand8(), rand8(), rand8(), rand8());
        else send_pixel(pixel_value());
      end
    end
    wait_for_results();

    $display("Run covered %0d input beats under %0d register settings.",
             sb.beat_count, $size(PLANS) + 2);
    $display("Checked %0d gray levels, %0d of them row ends and %0d image ends.",
             sb.gray_count, sb.row_end_count, sb.image_end_count);
    if (sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bpig_pkg.sv
rtl/bmp_pixel_to_inverted_gray_core.sv
test/bmp_pixel_to_inverted_gray_core_tb.sv
